// ----- rtl/core/bdq_pkg.sv -----
// bdq_pkg: shared types and constants of the bounded double-ended queue
`timescale 1ns / 1ps

package bdq_pkg;

    localparam int OP_W    = 3;
    localparam int VALUE_W = 32;
    localparam int CNT_W   = 5;
    localparam int DEPTH   = 16;

    localparam logic [CNT_W-1:0]   CAP_RESET   = 5'd16;
    localparam logic [VALUE_W-1:0] EMPTY_VALUE = 32'hFFFF_FFFF;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_REAR  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_REAR   = 3'd3,
        OP_STATUS     = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_RESP
    } t_state;

    typedef struct packed {
        logic load;
        logic exec;
        logic read;
    } t_dp_cmd;

endpackage

// ----- rtl/core/bdq_if.sv -----
// bdq_if: valid/ready channel interfaces for operation and result words
`timescale 1ns / 1ps

interface bdq_in_if;
    logic                                valid;
    logic                                ready;
    logic [bdq_pkg::OP_W-1:0]            operation;
    logic signed [bdq_pkg::VALUE_W-1:0]  push_value;

    modport source (output valid, output operation, output push_value, input ready);
    modport sink   (input valid, input operation, input push_value, output ready);
endinterface

interface bdq_out_if;
    logic                                valid;
    logic                                ready;
    logic                                success;
    logic signed [bdq_pkg::VALUE_W-1:0]  front_value;
    logic signed [bdq_pkg::VALUE_W-1:0]  rear_value;
    logic [bdq_pkg::CNT_W-1:0]           entry_count;
    logic                                is_empty;
    logic                                is_full;

    modport source (
        output valid, output success, output front_value, output rear_value,
        output entry_count, output is_empty, output is_full, input ready
    );
    modport sink (
        input valid, input success, input front_value, input rear_value,
        input entry_count, input is_empty, input is_full, output ready
    );
endinterface

// ----- rtl/core/bdq_ctrl.sv -----
// bdq_ctrl: sequencing state machine for one queue operation at a time
`timescale 1ns / 1ps

module bdq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_out_ready,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output bdq_pkg::t_dp_cmd  o_cmd
);

    bdq_pkg::t_state r_state;
    bdq_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bdq_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bdq_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = bdq_pkg::ST_EXEC;
                end
            end
            bdq_pkg::ST_EXEC: n_state = bdq_pkg::ST_READ;
            bdq_pkg::ST_READ: n_state = bdq_pkg::ST_RESP;
            bdq_pkg::ST_RESP: begin
                if (i_out_ready) begin
                    n_state = bdq_pkg::ST_IDLE;
                end
            end
            default: n_state = bdq_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            bdq_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            bdq_pkg::ST_EXEC: o_cmd.exec = 1'b1;
            bdq_pkg::ST_READ: o_cmd.read = 1'b1;
            bdq_pkg::ST_RESP: o_out_valid = 1'b1;
            default: o_cmd = '0;
        endcase
    end

endmodule

// ----- rtl/core/bdq_dp.sv -----
// bdq_dp: ring store, front pointer, occupancy and capacity datapath
`timescale 1ns / 1ps

module bdq_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  bdq_pkg::t_dp_cmd                    i_cmd,
    input  logic [bdq_pkg::OP_W-1:0]            i_operation,
    input  logic signed [bdq_pkg::VALUE_W-1:0]  i_push_value,
    input  logic                                i_cfg_we,
    input  logic [bdq_pkg::CNT_W-1:0]           i_cfg_wdata,
    output logic                                o_success,
    output logic signed [bdq_pkg::VALUE_W-1:0]  o_front_value,
    output logic signed [bdq_pkg::VALUE_W-1:0]  o_rear_value,
    output logic [bdq_pkg::CNT_W-1:0]           o_entry_count,
    output logic                                o_is_empty,
    output logic                                o_is_full
);

    localparam int DEPTH = bdq_pkg::DEPTH;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SUM_W = ((IDX_W > bdq_pkg::CNT_W) ? IDX_W : bdq_pkg::CNT_W) + 1;
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(DEPTH - 1);
    localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(DEPTH);

    logic [bdq_pkg::VALUE_W-1:0] mem [DEPTH];

    logic [bdq_pkg::OP_W-1:0]    r_op;
    logic [bdq_pkg::VALUE_W-1:0] r_value;
    logic [IDX_W-1:0]            r_front;
    logic [IDX_W-1:0]            n_front;
    logic [bdq_pkg::CNT_W-1:0]   r_occ;
    logic [bdq_pkg::CNT_W-1:0]   n_occ;
    logic [bdq_pkg::CNT_W-1:0]   r_cap;
    logic                        r_success;
    logic                        n_success;
    logic [bdq_pkg::VALUE_W-1:0] r_rd_front;
    logic [bdq_pkg::VALUE_W-1:0] r_rd_rear;

    logic [bdq_pkg::CNT_W-1:0]   eff_cap;
    logic                        at_cap;
    logic [IDX_W-1:0]            front_dec;
    logic [IDX_W-1:0]            front_inc;
    logic [SUM_W-1:0]            wr_sum;
    logic [SUM_W-1:0]            rd_sum;
    logic [IDX_W-1:0]            rear_wr_idx;
    logic [IDX_W-1:0]            rear_rd_idx;
    logic [IDX_W-1:0]            wr_idx;
    logic                        do_write;

    // capacity above the store depth saturates at the depth
    assign eff_cap = (32'(r_cap) > DEPTH) ? bdq_pkg::CNT_W'(DEPTH) : r_cap;
    assign at_cap  = (r_occ >= eff_cap);

    assign front_dec = (r_front == '0) ? LAST_IDX : r_front - 1'b1;
    assign front_inc = (r_front == LAST_IDX) ? '0 : r_front + 1'b1;

    // operands stay below twice the depth, so one subtract wraps them
    always_comb begin
        wr_sum = SUM_W'(r_front) + SUM_W'(r_occ);
        if (wr_sum >= DEPTH_SUM) begin
            wr_sum = wr_sum - DEPTH_SUM;
        end
        rd_sum = SUM_W'(r_front) + SUM_W'(r_occ - 1'b1);
        if (rd_sum >= DEPTH_SUM) begin
            rd_sum = rd_sum - DEPTH_SUM;
        end
    end

    assign rear_wr_idx = wr_sum[IDX_W-1:0];
    assign rear_rd_idx = rd_sum[IDX_W-1:0];

    always_comb begin
        n_front   = r_front;
        n_occ     = r_occ;
        n_success = 1'b1;
        do_write  = 1'b0;
        wr_idx    = rear_wr_idx;
        unique case (r_op)
            bdq_pkg::OP_PUSH_FRONT: begin
                if (at_cap) begin
                    n_success = 1'b0;
                end else begin
                    n_front  = front_dec;
                    n_occ    = r_occ + 1'b1;
                    do_write = 1'b1;
                    wr_idx   = front_dec;
                end
            end
            bdq_pkg::OP_PUSH_REAR: begin
                if (at_cap) begin
                    n_success = 1'b0;
                end else begin
                    n_occ    = r_occ + 1'b1;
                    do_write = 1'b1;
                end
            end
            bdq_pkg::OP_POP_FRONT: begin
                if (r_occ == '0) begin
                    n_success = 1'b0;
                end else begin
                    n_front = front_inc;
                    n_occ   = r_occ - 1'b1;
                end
            end
            bdq_pkg::OP_POP_REAR: begin
                if (r_occ == '0) begin
                    n_success = 1'b0;
                end else begin
                    n_occ = r_occ - 1'b1;
                end
            end
            default: n_success = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front   <= '0;
            r_occ     <= '0;
            r_cap     <= bdq_pkg::CAP_RESET;
            r_success <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (i_cmd.exec) begin
                r_front   <= n_front;
                r_occ     <= n_occ;
                r_success <= n_success;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_operation;
            r_value <= i_push_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && do_write) begin
            mem[wr_idx] <= r_value;
        end
        if (i_cmd.read) begin
            r_rd_front <= mem[r_front];
            r_rd_rear  <= mem[rear_rd_idx];
        end
    end

    assign o_success     = r_success;
    assign o_is_empty    = (r_occ == '0);
    assign o_is_full     = at_cap;
    assign o_entry_count = r_occ;
    assign o_front_value = o_is_empty ? bdq_pkg::EMPTY_VALUE : r_rd_front;
    assign o_rear_value  = o_is_empty ? bdq_pkg::EMPTY_VALUE : r_rd_rear;

endmodule

// ----- rtl/core/bounded_double_ended_queue_top.sv -----
// bounded_double_ended_queue_top: ring-store deque with operation and result channels
//
//  channel   dir   handshake     payload
//  i_in      in    valid/ready   operation, push_value
//  o_out     out   valid/ready   success, front_value, rear_value, entry_count,
//                                is_empty, is_full
//  i_cfg     in    write enable  capacity
//
// one operation at a time: the word is registered, the operation executes with the
// memory write for a push, then the registered two-port read of the front and rear
// entries; the result holds until taken, and the next word is accepted the cycle after that.
// reset clears pointer and count, sets capacity to 16; the store itself is not cleared.
`timescale 1ns / 1ps

module bounded_double_ended_queue_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    bdq_in_if.sink                     i_in,
    bdq_out_if.source                  o_out,
    input  logic                       i_cfg_we,
    input  logic [bdq_pkg::CNT_W-1:0]  i_cfg_wdata
);

    bdq_pkg::t_dp_cmd cmd;

    bdq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (cmd)
    );

    bdq_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_operation   (i_in.operation),
        .i_push_value  (i_in.push_value),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_success     (o_out.success),
        .o_front_value (o_out.front_value),
        .o_rear_value  (o_out.rear_value),
        .o_entry_count (o_out.entry_count),
        .o_is_empty    (o_out.is_empty),
        .o_is_full     (o_out.is_full)
    );

    // never taking a word while a result is still pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in.ready && o_out.valid))
        else $error("input accepted while a result is pending");

    // an accepted word yields its result after the execute and read states
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |-> ##3 o_out.valid)
        else $error("result not presented three cycles after acceptance");

    // an empty deque reports a zero count and the empty marker on both ends
    a_empty_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.is_empty) |->
            (o_out.entry_count == '0) && (o_out.front_value == -32'sd1)
            && (o_out.rear_value == -32'sd1))
        else $error("empty result with inconsistent fields");

endmodule

// ----- tb/tb_bounded_double_ended_queue_top.sv -----
// tb_bounded_double_ended_queue_top: self-checking directed and random testbench of the deque
`timescale 1ns / 1ps

module tb_bounded_double_ended_queue_top;

    localparam int OP_W    = bdq_pkg::OP_W;
    localparam int VALUE_W = bdq_pkg::VALUE_W;
    localparam int CNT_W   = bdq_pkg::CNT_W;

    localparam logic [CNT_W-1:0]   CAP_RESET   = bdq_pkg::CAP_RESET;
    localparam logic [VALUE_W-1:0] EMPTY_VALUE = bdq_pkg::EMPTY_VALUE;

    localparam int RING_DEPTH  = bdq_pkg::DEPTH;
    localparam int STUCK_LIMIT = 1000;
    localparam int SETTLE_CYCLES = 8;

    // codes above OP_STATUS behave as status only
    localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

    localparam logic [VALUE_W-1:0] VALUE_MIN = 32'h8000_0000;
    localparam logic [VALUE_W-1:0] VALUE_MAX = 32'h7FFF_FFFF;

    typedef enum logic [1:0] {
        ACT_WORD,
        ACT_CAP,
        ACT_SETTLE
    } t_act;

    typedef struct {
        t_act               act;
        logic [OP_W-1:0]    op;
        logic [VALUE_W-1:0] value;
        logic [CNT_W-1:0]   cap;
        int unsigned        gap;
        bit                 tail;
    } t_job;

    typedef struct packed {
        logic               success;
        logic [VALUE_W-1:0] front_value;
        logic [VALUE_W-1:0] rear_value;
        logic [CNT_W-1:0]   entry_count;
        logic               is_empty;
        logic               is_full;
    } t_result;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CNT_W-1:0]     cfg_wdata;

    bdq_in_if  in_ch ();
    bdq_out_if out_ch ();

    bounded_double_ended_queue_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in        (in_ch.sink),
        .o_out       (out_ch.source),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    // deque mirror
    logic [VALUE_W-1:0] ring [RING_DEPTH];
    logic [3:0]         head_ptr = '0;
    logic [CNT_W-1:0]   held     = '0;
    logic [CNT_W-1:0]   cap_reg  = CAP_RESET;

    t_job    pending [$];
    t_result expected [$];

    int unsigned words_in     = 0;
    int unsigned words_out    = 0;
    int unsigned fail_count   = 0;
    int unsigned stuck_cycles = 0;
    int unsigned cap_writes   = 0;
    int unsigned push_refused = 0;
    int unsigned pop_refused  = 0;
    int unsigned spare_codes  = 0;
    int unsigned deepest      = 0;

    // stimulus planning state
    logic [CNT_W-1:0] plan_cap  = CAP_RESET;
    logic [CNT_W-1:0] plan_held = '0;
    bit               filling   = 1'b1;

    bit          tail_mode  = 1'b0;
    int unsigned stall_left = 0;
    int unsigned mood_left  = 0;
    bit          calm_taker = 1'b0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [CNT_W-1:0] room_of(logic [CNT_W-1:0] cap);
        return (cap > RING_DEPTH) ? CNT_W'(RING_DEPTH) : cap;
    endfunction

    function automatic t_result deque_step(logic [OP_W-1:0] op, logic [VALUE_W-1:0] value);
        t_result          r;
        logic [CNT_W-1:0] room;
        logic [3:0]       rear_ptr;
        room      = room_of(cap_reg);
        r.success = 1'b1;
        case (op) inside
            bdq_pkg::OP_PUSH_FRONT, bdq_pkg::OP_PUSH_REAR: begin
                if (held >= room) begin
                    r.success = 1'b0;
                    push_refused++;
                end else begin
                    if (op == bdq_pkg::OP_PUSH_FRONT) begin
                        head_ptr       = head_ptr - 4'd1;
                        ring[head_ptr] = value;
                    end else begin
                        rear_ptr       = head_ptr + held[3:0];
                        ring[rear_ptr] = value;
                    end
                    held++;
                end
            end
            bdq_pkg::OP_POP_FRONT, bdq_pkg::OP_POP_REAR: begin
                if (held == 0) begin
                    r.success = 1'b0;
                    pop_refused++;
                end else begin
                    if (op == bdq_pkg::OP_POP_FRONT) head_ptr = head_ptr + 4'd1;
                    held--;
                end
            end
            bdq_pkg::OP_STATUS: ;
            default: spare_codes++;
        endcase
        if (held > deepest) deepest = held;
        rear_ptr      = head_ptr + held[3:0] - 4'd1;
        r.front_value = (held == 0) ? EMPTY_VALUE : ring[head_ptr];
        r.rear_value  = (held == 0) ? EMPTY_VALUE : ring[rear_ptr];
        r.entry_count = held;
        r.is_empty    = (held == 0);
        r.is_full     = (held >= room);
        return r;
    endfunction

    task automatic note_failure(string what, t_result want, t_result got);
        fail_count++;
        if (fail_count <= 10) begin
            $display("[%0t] mismatch:%s", $realtime, what);
            $display("    expected ok=%0b front=%0d rear=%0d count=%0d empty=%0b full=%0b",
                     want.success, $signed(want.front_value), $signed(want.rear_value),
                     want.entry_count, want.is_empty, want.is_full);
            $display("    actual   ok=%0b front=%0d rear=%0d count=%0d empty=%0b full=%0b",
                     got.success, $signed(got.front_value), $signed(got.rear_value),
                     got.entry_count, got.is_empty, got.is_full);
        end
    endtask

    task automatic queue_word(logic [OP_W-1:0] op, logic [VALUE_W-1:0] value,
                              int unsigned gap, bit tail);
        t_job j;
        j.act   = ACT_WORD;
        j.op    = op;
        j.value = value;
        j.cap   = '0;
        j.gap   = gap;
        j.tail  = tail;
        pending.push_back(j);
        // rough occupancy track so the random part can steer fill and drain
        if ((op == bdq_pkg::OP_PUSH_FRONT || op == bdq_pkg::OP_PUSH_REAR)
            && plan_held < room_of(plan_cap))
            plan_held++;
        else if ((op == bdq_pkg::OP_POP_FRONT || op == bdq_pkg::OP_POP_REAR)
                 && plan_held != 0)
            plan_held--;
    endtask

    task automatic queue_marker(t_act act, logic [CNT_W-1:0] cap);
        t_job j;
        j.act   = act;
        j.op    = bdq_pkg::OP_STATUS;
        j.value = '0;
        j.cap   = cap;
        j.gap   = 0;
        j.tail  = 1'b0;
        pending.push_back(j);
        if (act == ACT_CAP) plan_cap = cap;
    endtask

    task automatic random_run(int unsigned n, bit tail);
        int unsigned      k;
        int unsigned      r;
        int unsigned      gap;
        bit               calm;
        logic [OP_W-1:0]  op;
        logic [VALUE_W-1:0] v;
        calm = 1'b0;
        for (k = 0; k < n; k++) begin
            if (k % 25 == 0) calm = ($urandom_range(0, 2) == 0);
            if (filling && plan_held >= room_of(plan_cap) && $urandom_range(0, 2) == 0)
                filling = 1'b0;
            else if (!filling && plan_held == 0 && $urandom_range(0, 2) == 0)
                filling = 1'b1;
            r = $urandom_range(0, 99);
            if (r < 4)
                op = bdq_pkg::OP_STATUS;
            else if (r < 6)
                op = OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
            else if ((r < 82) == filling)
                op = $urandom_range(0, 1) ? bdq_pkg::OP_PUSH_FRONT : bdq_pkg::OP_PUSH_REAR;
            else
                op = $urandom_range(0, 1) ? bdq_pkg::OP_POP_FRONT : bdq_pkg::OP_POP_REAR;
            case ($urandom_range(0, 9))
                0:       v = VALUE_MIN;
                1:       v = VALUE_MAX;
                2:       v = '1;
                default: v = $urandom;
            endcase
            gap = (tail || calm || $urandom_range(0, 3) != 0) ? 0 : $urandom_range(1, 7);
            queue_word(op, v, gap, tail);
        end
    endtask

    // driver: one word, register write or settle point at a time
    always @(posedge clk) begin : word_driver
        logic next_valid;
        logic next_we;
        t_job job;
        next_valid = in_ch.valid;
        next_we    = 1'b0;
        if (!rst_n) begin
            next_valid = 1'b0;
        end else if (!in_ch.valid || in_ch.ready) begin
            next_valid = 1'b0;
            if (pending.size() != 0) begin
                job = pending[0];
                case (job.act)
                    ACT_WORD: begin
                        if (job.gap != 0) begin
                            pending[0].gap = job.gap - 1;
                        end else begin
                            in_ch.operation  <= job.op;
                            in_ch.push_value <= job.value;
                            next_valid = 1'b1;
                            if (job.tail) tail_mode <= 1'b1;
                            void'(pending.pop_front());
                        end
                    end
                    ACT_CAP: begin
                        // only once the block has handed back every result
                        if (!in_ch.valid && words_in == words_out) begin
                            next_we    = 1'b1;
                            cfg_wdata <= job.cap;
                            void'(pending.pop_front());
                        end
                    end
                    default: begin
                        if (!in_ch.valid && words_in == words_out)
                            void'(pending.pop_front());
                    end
                endcase
            end
        end
        in_ch.valid <= next_valid;
        cfg_we      <= next_we;
    end

    // result side back-pressure, with calm stretches
    always @(posedge clk) begin : result_taker
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (mood_left == 0) begin
                calm_taker = ($urandom_range(0, 2) == 0);
                mood_left  = $urandom_range(20, 120);
            end else begin
                mood_left--;
            end
            if (stall_left != 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else if (!tail_mode && !calm_taker && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 6);
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // monitor: predicts on accepted operation words, checks accepted result words
    always @(posedge clk) begin : observer
        t_result want;
        t_result got;
        string   diff;
        if (!rst_n) begin
            head_ptr = '0;
            held     = '0;
            cap_reg  = CAP_RESET;
        end else begin
            if (cfg_we) begin
                cap_reg = cfg_wdata;
                cap_writes++;
            end
            if (out_ch.valid && out_ch.ready) begin
                words_out <= words_out + 1;
                got = '{out_ch.success, out_ch.front_value, out_ch.rear_value,
                        out_ch.entry_count, out_ch.is_empty, out_ch.is_full};
                if (expected.size() == 0) begin
                    note_failure(" result word with nothing outstanding", got, got);
                end else begin
                    want = expected.pop_front();
                    diff = "";
                    if (got.success !== want.success)         diff = {diff, " success"};
                    if (got.front_value !== want.front_value) diff = {diff, " front_value"};
                    if (got.rear_value !== want.rear_value)   diff = {diff, " rear_value"};
                    if (got.entry_count !== want.entry_count) diff = {diff, " entry_count"};
                    if (got.is_empty !== want.is_empty)       diff = {diff, " is_empty"};
                    if (got.is_full !== want.is_full)         diff = {diff, " is_full"};
                    if (diff != "") note_failure(diff, want, got);
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                words_in <= words_in + 1;
                expected.push_back(deque_step(in_ch.operation, in_ch.push_value));
            end
        end
    end

    always @(posedge clk) begin : stuck_counter
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    initial begin : watchdog
        wait (stuck_cycles >= STUCK_LIMIT);
        $display("watchdog: no word moved for %0d cycles", STUCK_LIMIT);
        $display("status: fail");
        $finish;
    end

    initial begin : stimulus
        int unsigned k;
        rst_n = 1'b0;

        // empty deque, extreme values, spare codes, front push wrapping below index zero
        queue_word(bdq_pkg::OP_STATUS, '0, 0, 0);
        queue_word(bdq_pkg::OP_POP_FRONT, '0, 0, 0);
        queue_word(bdq_pkg::OP_POP_REAR, '0, 0, 0);
        queue_word(bdq_pkg::OP_PUSH_FRONT, VALUE_MIN, 0, 0);
        queue_word(bdq_pkg::OP_PUSH_REAR, VALUE_MAX, 0, 0);
        queue_word(bdq_pkg::OP_PUSH_FRONT, '1, 0, 0);
        queue_word(bdq_pkg::OP_PUSH_REAR, '0, 0, 0);
        for (k = OP_SPARE_FIRST; k <= OP_SPARE_LAST; k++)
            queue_word(OP_W'(k), $urandom, 0, 0);
        queue_word(bdq_pkg::OP_POP_FRONT, '0, 0, 0);
        queue_word(bdq_pkg::OP_POP_REAR, '0, 0, 0);
        queue_word(bdq_pkg::OP_POP_FRONT, '0, 0, 0);
        queue_word(bdq_pkg::OP_POP_REAR, '0, 0, 0);
        queue_word(bdq_pkg::OP_POP_REAR, '0, 0, 0);
        // single-entry deque
        queue_marker(ACT_CAP, 5'd1);
        queue_word(bdq_pkg::OP_PUSH_REAR, $urandom, 0, 0);
        queue_word(bdq_pkg::OP_PUSH_FRONT, $urandom, 0, 0);
        queue_word(bdq_pkg::OP_POP_FRONT, '0, 0, 0);
        queue_word(bdq_pkg::OP_POP_FRONT, '0, 0, 0);
        // zero capacity: full and empty at once
        queue_marker(ACT_CAP, 5'd0);
        queue_word(bdq_pkg::OP_PUSH_REAR, $urandom, 0, 0);
        queue_word(bdq_pkg::OP_POP_REAR, '0, 0, 0);
        queue_word(bdq_pkg::OP_STATUS, '0, 0, 0);

        queue_marker(ACT_CAP, 5'd16);
        random_run(200, 0);
        queue_marker(ACT_CAP, 5'd31);     // saturates at the ring depth
        random_run(180, 0);
        queue_marker(ACT_CAP, 5'd17);
        random_run(150, 0);
        queue_marker(ACT_SETTLE, '0);
        queue_marker(ACT_CAP, 5'd1);
        random_run(120, 0);
        queue_marker(ACT_CAP, 5'd2);
        random_run(150, 0);
        // lower the capacity under a well-filled deque
        queue_marker(ACT_CAP, 5'd16);
        for (k = 0; k < 12; k++)
            queue_word(bdq_pkg::OP_PUSH_REAR, $urandom, 0, 0);
        queue_marker(ACT_CAP, 5'd5);
        random_run(150, 0);
        queue_marker(ACT_CAP, 5'd0);
        random_run(40, 0);
        queue_marker(ACT_CAP, CNT_W'($urandom_range(3, 15)));
        random_run(200, 0);
        queue_marker(ACT_CAP, 5'd16);
        random_run(200, 0);
        queue_marker(ACT_SETTLE, '0);
        random_run(200, 0);
        queue_marker(ACT_CAP, 5'd8);
        random_run(150, 0);
        queue_marker(ACT_CAP, 5'd16);
        random_run(150, 1);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (pending.size() != 0 || in_ch.valid || words_in != words_out)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected.size() != 0) begin
            fail_count++;
            $display("%0d expected result words never arrived", expected.size());
        end

        $display("ran %0d operation words, checked %0d results, %0d capacity writes",
                 words_in, words_out, cap_writes);
        $display("refused pushes %0d, refused pops %0d, spare codes %0d, deepest fill %0d",
                 push_refused, pop_refused, spare_codes, deepest);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/bdq_pkg.sv
rtl/core/bdq_if.sv
rtl/core/bdq_ctrl.sv
rtl/core/bdq_dp.sv
rtl/core/bounded_double_ended_queue_top.sv
tb/tb_bounded_double_ended_queue_top.sv
